### hdl/bnfa_pkg.sv
package bnfa_pkg;

  localparam int WORD_BITS = 64;
  localparam int OFF_W = 13;
  localparam logic [OFF_W-1:0] OFFSET_NONE = 13'h1FFF;

  typedef enum logic [2:0] {
    CMD_INIT     = 3'd0,
    CMD_FIND     = 3'd1,
    CMD_FIND_CLR = 3'd2,
    CMD_SET      = 3'd3,
    CMD_CLR      = 3'd4,
    CMD_TEST     = 3'd5
  } cmd_t;

  // Index of the lowest set bit, found by halving the word six times.
  // An all-zero word gives 63.
  function automatic logic [5:0] lowest_set(input logic [WORD_BITS-1:0] w);
    logic [WORD_BITS-1:0] v;
    logic [5:0] idx;
    v = w;
    idx = '0;
    for (int k = 5; k >= 0; k--) begin
      if ((v & ((64'd1 << (1 << k)) - 64'd1)) == 64'd0) begin
        idx[k] = 1'b1;
        v = v >> (1 << k);
      end
    end
    return idx;
  endfunction

endpackage

### hdl/bitmap_next_fit_allocator.sv
// Next-fit bitmap allocator. The bitmap lives in a single-port word memory
// (MAX_WORDS x 64 bits, one access per cycle), and one small sequencer with a
// shared lowest-bit encoder carries out each command. After reset the block
// clears the memory one word a cycle, so busy stays high until the last word is cleared.
// A command is taken when start is high and busy is low. Its result appears
// on found, found_offset, set_count and range_error for exactly one cycle
// with done high; the receiver must take it then, since there is no stall.
// Init writes the words in use one after another; a search reads and checks
// one word after another from the cursor, wrapping at the words in use, until
// it finds a set bit or has visited each word in use; set, clear and test read
// the addressed word, then test or update its bit; commands with an empty
// bitmap, an offset out of range or an unused code are answered from idle.
module bitmap_next_fit_allocator #(
  parameter int MAX_WORDS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         cmd,
  input  logic [11:0]        bit_offset,
  input  logic               flag,
  input  logic [6:0]         word_count,
  output logic               done,
  output logic               found,
  output logic signed [12:0] found_offset,
  output logic [12:0]        set_count,
  output logic               range_error
);

  localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int CW = $clog2(MAX_WORDS + 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_INIT,
    S_RD,
    S_CHK,
    S_BIT
  } state_t;

  state_t state;

  logic [63:0]   mem [MAX_WORDS];
  logic [63:0]   rd_data;
  logic          mem_we;
  logic [63:0]   mem_wdata;

  logic [AW-1:0] addr;
  logic [AW-1:0] cursor;
  logic [CW-1:0] words_in_use;
  logic [CW-1:0] remain;
  logic [12:0]   ones_count;
  logic [2:0]    op;
  logic [5:0]    bidx;
  logic          op_flag;
  logic          fill;

  logic [5:0]    hit_bit;
  logic [63:0]   bit_mask;
  logic          bit_is_set;
  logic [CW-1:0] wc_sat;
  logic [5:0]    off_word;

  assign set_count = ones_count;
  assign off_word  = bit_offset[11:6];

  always_comb begin
    if (32'(word_count) > MAX_WORDS) begin
      wc_sat = CW'(MAX_WORDS);
    end else begin
      wc_sat = CW'(word_count);
    end
  end

  always_comb begin
    hit_bit    = bnfa_pkg::lowest_set(rd_data);
    bit_mask   = 64'd1 << bidx;
    bit_is_set = (rd_data & bit_mask) != 64'd0;
    mem_we     = 1'b0;
    mem_wdata  = rd_data;
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
      end
      S_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = {64{fill}};
      end
      S_CHK: begin
        if (op == bnfa_pkg::CMD_FIND_CLR && rd_data != 64'd0) begin
          mem_we    = 1'b1;
          mem_wdata = rd_data & ~(64'd1 << hit_bit);
        end
      end
      S_BIT: begin
        if (op == bnfa_pkg::CMD_SET && !bit_is_set) begin
          mem_we    = 1'b1;
          mem_wdata = rd_data | bit_mask;
        end else if (op == bnfa_pkg::CMD_CLR && bit_is_set) begin
          mem_we    = 1'b1;
          mem_wdata = rd_data & ~bit_mask;
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr] <= mem_wdata;
    end
    rd_data <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      busy         <= 1'b1;
      done         <= 1'b0;
      addr         <= '0;
      cursor       <= '0;
      words_in_use <= '0;
      ones_count   <= '0;
      remain       <= '0;
      op           <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          if (addr == AW'(MAX_WORDS - 1)) begin
            state <= S_IDLE;
            busy  <= 1'b0;
            addr  <= '0;
          end else begin
            addr <= addr + 1'b1;
          end
        end

        S_IDLE: begin
          if (start) begin
            op           <= cmd;
            bidx         <= bit_offset[5:0];
            op_flag      <= flag;
            found        <= 1'b0;
            found_offset <= bnfa_pkg::OFFSET_NONE;
            range_error  <= 1'b0;
            case (cmd)
              bnfa_pkg::CMD_INIT: begin
                words_in_use <= wc_sat;
                ones_count   <= flag ? 13'd0 : 13'({wc_sat, 6'd0});
                cursor       <= '0;
                fill         <= !flag;
                addr         <= '0;
                remain       <= wc_sat;
                if (wc_sat == '0) begin
                  done <= 1'b1;
                end else begin
                  state <= S_INIT;
                  busy  <= 1'b1;
                end
              end
              bnfa_pkg::CMD_FIND, bnfa_pkg::CMD_FIND_CLR: begin
                if (ones_count == 13'd0 || words_in_use == '0) begin
                  done <= 1'b1;
                end else begin
                  // A stale cursor beyond the words in use restarts at word 0.
                  addr   <= (32'(cursor) < 32'(words_in_use)) ? cursor : '0;
                  remain <= words_in_use;
                  state  <= S_RD;
                  busy   <= 1'b1;
                end
              end
              bnfa_pkg::CMD_SET, bnfa_pkg::CMD_CLR, bnfa_pkg::CMD_TEST: begin
                if (32'(off_word) >= 32'(words_in_use)) begin
                  range_error <= 1'b1;
                  done        <= 1'b1;
                end else begin
                  addr  <= AW'(off_word);
                  state <= S_RD;
                  busy  <= 1'b1;
                end
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end

        S_INIT: begin
          if (remain == CW'(1)) begin
            state <= S_IDLE;
            busy  <= 1'b0;
            done  <= 1'b1;
          end else begin
            addr   <= addr + 1'b1;
            remain <= remain - 1'b1;
          end
        end

        S_RD: begin
          if (op == bnfa_pkg::CMD_FIND || op == bnfa_pkg::CMD_FIND_CLR) begin
            state <= S_CHK;
          end else begin
            state <= S_BIT;
          end
        end

        S_CHK: begin
          if (rd_data != 64'd0) begin
            found        <= 1'b1;
            found_offset <= 13'({addr, hit_bit});
            cursor       <= addr;
            if (op == bnfa_pkg::CMD_FIND_CLR) begin
              ones_count <= ones_count - 13'd1;
            end
            state <= S_IDLE;
            busy  <= 1'b0;
            done  <= 1'b1;
          end else if (remain == CW'(1)) begin
            state <= S_IDLE;
            busy  <= 1'b0;
            done  <= 1'b1;
          end else begin
            if (32'(addr) + 32'd1 == 32'(words_in_use)) begin
              addr <= '0;
            end else begin
              addr <= addr + 1'b1;
            end
            remain <= remain - 1'b1;
            state  <= S_RD;
          end
        end

        S_BIT: begin
          case (op)
            bnfa_pkg::CMD_SET: begin
              if (!bit_is_set) begin
                found      <= 1'b1;
                ones_count <= ones_count + 13'd1;
                // The first set bit, or a requested backward move, pulls the cursor.
                if (ones_count == 13'd0 || (op_flag && addr < cursor)) begin
                  cursor <= addr;
                end
              end
            end
            bnfa_pkg::CMD_CLR: begin
              if (bit_is_set) begin
                found      <= 1'b1;
                ones_count <= ones_count - 13'd1;
              end
            end
            default: begin
              found <= bit_is_set;
            end
          endcase
          state <= S_IDLE;
          busy  <= 1'b0;
          done  <= 1'b1;
        end

        default: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  a_no_result_in_clear: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !done)
    else $error("result strobe during the clearing pass");

  a_range_not_found: assert property (@(posedge clk) disable iff (rst)
    done |-> !(range_error && found))
    else $error("range error reported together with found");

  a_miss_offset: assert property (@(posedge clk) disable iff (rst)
    done && !found |-> found_offset == bnfa_pkg::OFFSET_NONE)
    else $error("offset given without a hit");

  a_transfer_answered: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy || done)
    else $error("transfer neither answered nor started");

endmodule

### verif/bitmap_next_fit_allocator_tb.sv
`timescale 1ns / 1ps

module bitmap_next_fit_allocator_tb;

  localparam logic [2:0]  CMD_INIT     = bnfa_pkg::CMD_INIT;
  localparam logic [2:0]  CMD_FIND     = bnfa_pkg::CMD_FIND;
  localparam logic [2:0]  CMD_FIND_CLR = bnfa_pkg::CMD_FIND_CLR;
  localparam logic [2:0]  CMD_SET      = bnfa_pkg::CMD_SET;
  localparam logic [2:0]  CMD_CLR      = bnfa_pkg::CMD_CLR;
  localparam logic [2:0]  CMD_TEST     = bnfa_pkg::CMD_TEST;
  localparam logic [12:0] OFFSET_NONE  = bnfa_pkg::OFFSET_NONE;
  localparam logic [2:0] CMD_RSVD6 = 3'd6;
  localparam logic [2:0] CMD_RSVD7 = 3'd7;
  localparam int NUM_WORDS = 64;
  localparam int RANDOM_ITEMS = 1650;
  // Idle time at the end, sized to cover the longest search plus a margin.
  localparam int DRAIN_CYCLES = 2 * NUM_WORDS + 20;

  typedef struct packed {
    logic        found;
    logic [12:0] offset;
    logic [12:0] count;
    logic        rerr;
  } alloc_result_t;

  typedef struct {
    logic [2:0]    c;
    logic [11:0]   off;
    logic          f;
    logic [6:0]    wc;
    bit            typed;
    alloc_result_t res;
  } dir_row_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [2:0]         cmd;
  logic [11:0]        bit_offset;
  logic               flag;
  logic [6:0]         word_count;
  logic               done;
  logic               found;
  logic signed [12:0] found_offset;
  logic [12:0]        set_count;
  logic               range_error;

  // Mirror of the allocator state.
  logic [63:0] bitmap [NUM_WORDS];
  logic [6:0]  words_used;
  logic [12:0] ones;
  logic [5:0]  cursor;

  alloc_result_t pending_results [$];
  dir_row_t      directed [$];
  int            errors = 0;

  bitmap_next_fit_allocator #(
    .MAX_WORDS(NUM_WORDS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .bit_offset(bit_offset),
    .flag(flag),
    .word_count(word_count),
    .done(done),
    .found(found),
    .found_offset(found_offset),
    .set_count(set_count),
    .range_error(range_error)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Applies one command to the mirror and returns the result it should give.
  function automatic alloc_result_t alloc_step(logic [2:0] c, logic [11:0] off, logic f,
                                               logic [6:0] wc);
    alloc_result_t r;
    logic [6:0]    n;
    logic [5:0]    wi;
    int            first_w;
    int            w;
    int            b;
    logic          hit;
    r.found = 1'b0;
    r.offset = OFFSET_NONE;
    r.rerr = 1'b0;
    case (c)
      CMD_INIT: begin
        n = (wc > NUM_WORDS) ? 7'(NUM_WORDS) : wc;
        for (int i = 0; i < n; i++) bitmap[i] = f ? 64'd0 : '1;
        words_used = n;
        ones = f ? 13'd0 : {n, 6'd0};
        cursor = '0;
      end
      CMD_FIND, CMD_FIND_CLR: begin
        if (ones != 0 && words_used != 0) begin
          // The search wraps from the last word in use back to word 0.
          first_w = (cursor < words_used) ? cursor : 0;
          hit = 1'b0;
          for (int i = 0; i < words_used && !hit; i++) begin
            w = first_w + i;
            if (w >= words_used) w -= words_used;
            if (bitmap[w] != 64'd0) begin
              hit = 1'b1;
              b = 0;
              while (!bitmap[w][b]) b++;
              if (c == CMD_FIND_CLR) begin
                bitmap[w][b] = 1'b0;
                ones = ones - 13'd1;
              end
              cursor = 6'(w);
              r.found = 1'b1;
              r.offset = 13'(w * 64 + b);
            end
          end
        end
      end
      CMD_SET, CMD_CLR, CMD_TEST: begin
        wi = off[11:6];
        if ({1'b0, wi} >= words_used) begin
          r.rerr = 1'b1;
        end else if (c == CMD_SET) begin
          if (!bitmap[wi][off[5:0]]) begin
            bitmap[wi][off[5:0]] = 1'b1;
            ones = ones + 13'd1;
            r.found = 1'b1;
            if (ones == 13'd1 || (f && wi < cursor)) cursor = wi;
          end
        end else if (c == CMD_CLR) begin
          if (bitmap[wi][off[5:0]]) begin
            bitmap[wi][off[5:0]] = 1'b0;
            ones = ones - 13'd1;
            r.found = 1'b1;
          end
        end else begin
          r.found = bitmap[wi][off[5:0]];
        end
      end
      default: ;
    endcase
    r.count = ones;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic logic [6:0] pick_word_count();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 7'($urandom_range(4, 1));
    if (r < 90) return 7'($urandom_range(NUM_WORDS, 5));
    if (r < 95) return 7'd0;
    return 7'($urandom_range(127, NUM_WORDS + 1));
  endfunction

  // Offsets mostly land inside the words in use so that set, clear and test
  // reach the bitmap; the rest cover the whole field.
  function automatic logic [11:0] pick_offset();
    if (words_used != 0 && $urandom_range(99) < 85)
      return 12'($urandom_range(words_used * 64 - 1));
    return 12'($urandom_range(4095));
  endfunction

  // Presents one command and returns at the edge of its transfer. With drain
  // set, start is held low until every outstanding result has come back.
  task automatic send_cmd(input logic [2:0] c, input logic [11:0] off, input logic f,
                          input logic [6:0] wc, input int gap, input bit drain,
                          input bit typed, input alloc_result_t typed_res);
    alloc_result_t r;
    if (gap > 0 || (drain && pending_results.size() != 0)) begin
      start <= 1'b0;
      while (drain && pending_results.size() != 0) @(posedge clk);
      repeat (gap) @(posedge clk);
    end
    cmd <= c;
    bit_offset <= off;
    flag <= f;
    word_count <= wc;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    r = alloc_step(c, off, f, wc);
    pending_results.push_back(typed ? typed_res : r);
  endtask

  task automatic add_row(input logic [2:0] c, input logic [11:0] off, input logic f,
                         input logic [6:0] wc, input bit typed, input logic fnd,
                         input logic [12:0] foff, input logic [12:0] cnt, input logic rerr);
    dir_row_t row;
    row.c = c;
    row.off = off;
    row.f = f;
    row.wc = wc;
    row.typed = typed;
    row.res = '{found: fnd, offset: foff, count: cnt, rerr: rerr};
    directed.push_back(row);
  endtask

  always @(posedge clk) begin : check_results
    alloc_result_t exp_res;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("result with no command outstanding");
        errors++;
      end else begin
        exp_res = pending_results.pop_front();
        if (found !== exp_res.found) begin
          $error("found: expected %0d, actual %0d", exp_res.found, found);
          errors++;
        end
        if (found_offset !== exp_res.offset) begin
          $error("found_offset: expected %0d, actual %0d", $signed(exp_res.offset),
                 found_offset);
          errors++;
        end
        if (set_count !== exp_res.count) begin
          $error("set_count: expected %0d, actual %0d", exp_res.count, set_count);
          errors++;
        end
        if (range_error !== exp_res.rerr) begin
          $error("range_error: expected %0d, actual %0d", exp_res.rerr, range_error);
          errors++;
        end
      end
    end
  end

  initial begin
    #12ms;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int            sent;
    int            phase_len;
    int            sel;
    bit            quiet;
    logic [2:0]    c;
    logic [6:0]    wc;
    for (int i = 0; i < NUM_WORDS; i++) bitmap[i] = 64'd0;
    words_used = '0;
    ones = '0;
    cursor = '0;
    rst = 1'b1;
    start = 1'b0;
    cmd = CMD_INIT;
    bit_offset = '0;
    flag = 1'b0;
    word_count = '0;

    // Empty bitmap after reset, saturation of the word count, wrap-around,
    // repeated set and clear, reserved codes and cursor moves.
    add_row(CMD_FIND,     12'd0,    1'b0, 7'd0,   1, 1'b0, OFFSET_NONE, 13'd0,    1'b0);
    add_row(CMD_SET,      12'd0,    1'b0, 7'd0,   1, 1'b0, OFFSET_NONE, 13'd0,    1'b1);
    add_row(CMD_INIT,     12'd0,    1'b0, 7'd0,   1, 1'b0, OFFSET_NONE, 13'd0,    1'b0);
    add_row(CMD_INIT,     12'hFFF,  1'b0, 7'd127, 1, 1'b0, OFFSET_NONE, 13'd4096, 1'b0);
    add_row(CMD_FIND_CLR, 12'd0,    1'b0, 7'd0,   1, 1'b1, 13'd0,       13'd4095, 1'b0);
    add_row(CMD_FIND,     12'd0,    1'b0, 7'd0,   1, 1'b1, 13'd1,       13'd4095, 1'b0);
    add_row(CMD_TEST,     12'd4095, 1'b0, 7'd0,   1, 1'b1, OFFSET_NONE, 13'd4095, 1'b0);
    add_row(CMD_CLR,      12'd4095, 1'b0, 7'd0,   1, 1'b1, OFFSET_NONE, 13'd4094, 1'b0);
    add_row(CMD_CLR,      12'd4095, 1'b0, 7'd0,   1, 1'b0, OFFSET_NONE, 13'd4094, 1'b0);
    add_row(CMD_SET,      12'd4095, 1'b1, 7'd0,   1, 1'b1, OFFSET_NONE, 13'd4095, 1'b0);
    add_row(CMD_RSVD6,    12'd4095, 1'b1, 7'd127, 1, 1'b0, OFFSET_NONE, 13'd4095, 1'b0);
    add_row(CMD_RSVD7,    12'd0,    1'b0, 7'd0,   1, 1'b0, OFFSET_NONE, 13'd4095, 1'b0);
    add_row(CMD_SET,      12'd4095, 1'b0, 7'd0,   1, 1'b0, OFFSET_NONE, 13'd4095, 1'b0);
    add_row(CMD_INIT,     12'd0,    1'b1, 7'd1,   1, 1'b0, OFFSET_NONE, 13'd0,    1'b0);
    add_row(CMD_TEST,     12'd64,   1'b0, 7'd0,   1, 1'b0, OFFSET_NONE, 13'd0,    1'b1);
    add_row(CMD_FIND_CLR, 12'd0,    1'b0, 7'd0,   1, 1'b0, OFFSET_NONE, 13'd0,    1'b0);
    add_row(CMD_SET,      12'd63,   1'b0, 7'd0,   1, 1'b1, OFFSET_NONE, 13'd1,    1'b0);
    add_row(CMD_INIT,     12'd0,    1'b1, 7'd64,  1, 1'b0, OFFSET_NONE, 13'd0,    1'b0);
    add_row(CMD_SET,      12'd4000, 1'b0, 7'd0,   1, 1'b1, OFFSET_NONE, 13'd1,    1'b0);
    add_row(CMD_SET,      12'd5,    1'b0, 7'd0,   1, 1'b1, OFFSET_NONE, 13'd2,    1'b0);
    add_row(CMD_FIND,     12'd0,    1'b0, 7'd0,   1, 1'b1, 13'd4000,    13'd2,    1'b0);
    add_row(CMD_SET,      12'd70,   1'b1, 7'd0,   0, 1'b0, '0,          '0,       1'b0);
    add_row(CMD_FIND,     12'd0,    1'b0, 7'd0,   0, 1'b0, '0,          '0,       1'b0);
    add_row(CMD_FIND_CLR, 12'd0,    1'b0, 7'd0,   0, 1'b0, '0,          '0,       1'b0);
    add_row(CMD_FIND_CLR, 12'd0,    1'b0, 7'd0,   0, 1'b0, '0,          '0,       1'b0);
    add_row(CMD_FIND_CLR, 12'd0,    1'b0, 7'd0,   0, 1'b0, '0,          '0,       1'b0);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i])
      send_cmd(directed[i].c, directed[i].off, directed[i].f, directed[i].wc, pick_gap(),
               1'b0, directed[i].typed, directed[i].res);

    // Each phase starts from a fresh init once the previous phase has drained,
    // then mixes allocations and frees so that searches see partly full maps.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      quiet = ($urandom_range(3) == 0);
      phase_len = $urandom_range(180, 60);
      send_cmd(CMD_INIT, 12'($urandom_range(4095)), 1'($urandom_range(1)), pick_word_count(),
               quiet ? 0 : pick_gap(), 1'b1, 1'b0, '0);
      sent++;
      for (int k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
        sel = $urandom_range(99);
        wc = 7'($urandom_range(127));
        if (sel < 28) c = CMD_SET;
        else if (sel < 42) c = CMD_CLR;
        else if (sel < 56) c = CMD_TEST;
        else if (sel < 71) c = CMD_FIND;
        else if (sel < 93) c = CMD_FIND_CLR;
        else if (sel < 95) c = $urandom_range(1) ? CMD_RSVD6 : CMD_RSVD7;
        else begin
          c = CMD_INIT;
          wc = pick_word_count();
        end
        send_cmd(c, pick_offset(), 1'($urandom_range(1)), wc, quiet ? 0 : pick_gap(), 1'b0,
                 1'b0, '0);
        sent++;
      end
    end

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
